@@ sv/path_canonicalizer_assert.svh @@
// Assertion macros for the path canonicaliser.
// Each macro expects clk and rst in scope at the point of use.
`ifndef PATH_CANONICALIZER_ASSERT_SVH
`define PATH_CANONICALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCAN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCAN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pcan_pkg.sv @@
// Shared types and constants for the path canonicaliser.
// No dependencies; the interfaces and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package pcan_pkg;

  // Fixed field widths of the beats.
  localparam int CH_W    = 8;
  localparam int IDX_W   = 12;
  localparam int LEN_W   = 13;

  // Operation codes carried in the op field.
  localparam logic OP_PATH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Characters with a special meaning in a path.
  localparam logic [CH_W-1:0] SLASH_CH = 8'h2F;
  localparam logic [CH_W-1:0] DOT_CH   = 8'h2E;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_READ = 4'b0100,
    S_HOLD = 4'b1000
  } pcan_state_t;

  // Source of the character returned by a read.
  typedef enum logic [1:0] {
    RD_ZERO  = 2'd0,
    RD_SLASH = 2'd1,
    RD_MEM   = 2'd2
  } pcan_rd_sel_t;

endpackage

`default_nettype wire

@@ sv/pcan_in_if.sv @@
// Request channel of the path canonicaliser: path bytes and read requests.
// Depends on pcan_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pcan_in_if import pcan_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [CH_W-1:0]  ch;
  logic             last;
  logic [IDX_W-1:0] index;

  modport source (output valid, op, ch, last, index, input ready);
  modport sink   (input valid, op, ch, last, index, output ready);
endinterface

`default_nettype wire

@@ sv/pcan_out_if.sv @@
// Response channel of the path canonicaliser: one beat per request.
// Depends on pcan_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pcan_out_if import pcan_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_char;
  logic [LEN_W-1:0] canon_length;
  logic             overflow;

  modport source (output valid, out_char, canon_length, overflow, input ready);
  modport sink   (input valid, out_char, canon_length, overflow, output ready);
endinterface

`default_nettype wire

@@ sv/path_canonicalizer.sv @@
// Streaming path canonicaliser. A path byte is handled in S_IDLE, and also in S_POP when
// a ".." pops the segment stack (one stack read); a read passes S_READ via the read port.
// One request is worked on at a time; the response sits in an output register, so the
// next request is taken while it waits. Reset (synchronous) clears control registers;
// payload registers, path buffer and segment stack are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module path_canonicalizer import pcan_pkg::*; #(
  parameter int MAX_PATH_LEN = 4096,
  parameter int STACK_DEPTH  = 2048
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pcan_in_if.sink     req,
  pcan_out_if.source  rsp
);

  `include "path_canonicalizer_assert.svh"

  localparam int PW  = $clog2(MAX_PATH_LEN + 1);
  localparam int BAW = $clog2(MAX_PATH_LEN);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);

  // Memories: kept path bytes and start offsets of kept segments.
  logic [CH_W-1:0] pbuf_mem [MAX_PATH_LEN];
  logic [BAW-1:0]  stk_mem  [STACK_DEPTH];

  logic            pbuf_we, pbuf_re;
  logic [BAW-1:0]  pbuf_waddr, pbuf_raddr;
  logic [CH_W-1:0] pbuf_wdata, pbuf_rdata;
  logic            stk_we, stk_re;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [BAW-1:0]  stk_wdata, stk_rdata;

  // Control state.
  pcan_state_t      state, state_next;
  logic [SCW-1:0]   sc, sc_next;
  logic [PW-1:0]    ce, ce_next;
  logic [PW-1:0]    wp, wp_next;
  logic [1:0]       pc, pc_next;
  logic [1:0]       pd, pd_next;
  logic             done, done_next;
  logic             ovf, ovf_next;
  logic             pop_slash, pop_slash_next;
  logic             pop_last, pop_last_next;
  pcan_rd_sel_t     rd_sel, rd_sel_next;
  logic [CH_W-1:0]  hold_char, hold_char_next;

  // Output register.
  logic             o_valid, o_valid_next;
  logic [CH_W-1:0]  o_char, o_char_next;
  logic [LEN_W-1:0] o_len, o_len_next;
  logic             o_ovf, o_ovf_next;

  // Effective state seen by a path byte: a finished path starts afresh.
  logic [SCW-1:0] e_sc;
  logic [PW-1:0]  e_ce, e_wp;
  logic [1:0]     e_pc, e_pd;
  logic           is_slash, is_dot;

  // Ordinary byte appended at the write pointer.
  logic           np_fit;
  logic [PW-1:0]  p_wp;
  logic [1:0]     p_pc, p_pd;

  // Segment close decision.
  logic           cl_en, cls_drop, cls_dd, cl_pop, cl_keep, cl_push, cl_full;
  logic [1:0]     cl_pc, cl_pd;
  logic [PW-1:0]  cl_wp, c_ce;
  logic [SCW-1:0] c_sc;

  // Slash written after the close.
  logic           sp_fit;
  logic [PW-1:0]  sp_wp;

  // Popped offset from the stack.
  logic [PW-1:0]  pop_ce;

  logic           out_free, finish;
  logic [CH_W-1:0] res_char;

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (pbuf_we) begin
      pbuf_mem[pbuf_waddr] <= pbuf_wdata;
    end
    if (pbuf_re) begin
      pbuf_rdata <= pbuf_mem[pbuf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  // Byte classification and the effective state of the current path.
  always_comb begin
    e_sc     = done ? '0 : sc;
    e_ce     = done ? '0 : ce;
    e_wp     = done ? '0 : wp;
    e_pc     = done ? '0 : pc;
    e_pd     = done ? '0 : pd;
    is_slash = (req.ch == SLASH_CH);
    is_dot   = (req.ch == DOT_CH);
  end

  // Append of an ordinary byte; a leading segment without a slash is always kept.
  always_comb begin
    np_fit = (e_wp < PW'(MAX_PATH_LEN));
    p_wp   = np_fit ? e_wp + PW'(1) : e_wp;
    if (e_wp == '0) begin
      p_pc = 2'd3;
      p_pd = e_pd;
    end else begin
      p_pc = (e_pc == 2'd3) ? e_pc : e_pc + 2'd1;
      p_pd = (is_dot && e_pd != 2'd3) ? e_pd + 2'd1 : e_pd;
    end
  end

  // Close of the current segment: drop, pop on "..", or push when bytes were kept and the stack has room.
  always_comb begin
    cl_en    = is_slash ? (e_wp != '0) : req.last;
    cl_pc    = is_slash ? e_pc : p_pc;
    cl_pd    = is_slash ? e_pd : p_pd;
    cl_wp    = is_slash ? e_wp : p_wp;
    cls_drop = (cl_pc == 2'd0) || (cl_pc == 2'd1 && cl_pd == 2'd1);
    cls_dd   = (cl_pc == 2'd2) && (cl_pd == 2'd2);
    cl_pop   = cl_en && cls_dd && (e_sc != '0);
    cl_keep  = cl_en && !cls_drop && !cls_dd && (cl_wp > e_ce);
    cl_push  = cl_keep && (e_sc < SCW'(STACK_DEPTH));
    cl_full  = cl_keep && !cl_push;
    c_ce     = cl_push ? cl_wp : e_ce;
    c_sc     = cl_push ? e_sc + SCW'(1) : e_sc;
    sp_fit   = (c_ce < PW'(MAX_PATH_LEN));
    sp_wp    = sp_fit ? c_ce + PW'(1) : c_ce;
    pop_ce   = PW'(stk_rdata);
  end

  assign out_free = !o_valid || rsp.ready;

  // Sequencer: decision, memory accesses and result hand-off.
  always_comb begin
    state_next     = state;
    sc_next        = sc;
    ce_next        = ce;
    wp_next        = wp;
    pc_next        = pc;
    pd_next        = pd;
    done_next      = done;
    ovf_next       = ovf;
    pop_slash_next = pop_slash;
    pop_last_next  = pop_last;
    rd_sel_next    = rd_sel;
    hold_char_next = hold_char;
    o_valid_next   = o_valid && !rsp.ready;
    o_char_next    = o_char;
    o_len_next     = o_len;
    o_ovf_next     = o_ovf;
    pbuf_we        = 1'b0;
    pbuf_waddr     = e_wp[BAW-1:0];
    pbuf_wdata     = req.ch;
    pbuf_re        = 1'b0;
    pbuf_raddr     = BAW'(req.index);
    stk_we         = 1'b0;
    stk_waddr      = e_sc[SAW-1:0];
    stk_wdata      = e_ce[BAW-1:0];
    stk_re         = 1'b0;
    stk_raddr      = SAW'(e_sc - SCW'(1));
    finish         = 1'b0;
    res_char       = '0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.op == OP_READ) begin
            // Look up the canonical byte; the data returns next cycle.
            pbuf_re = 1'b1;
            if (ce == '0) begin
              rd_sel_next = (req.index == '0) ? RD_SLASH : RD_ZERO;
            end else begin
              rd_sel_next = (32'(req.index) < 32'(ce)) ? RD_MEM : RD_ZERO;
            end
            state_next = S_READ;
          end else begin
            sc_next   = e_sc;
            ce_next   = e_ce;
            wp_next   = e_wp;
            pc_next   = e_pc;
            pd_next   = e_pd;
            done_next = 1'b0;
            if (!is_slash) begin
              // Ordinary byte goes in before any close.
              pbuf_we    = np_fit;
              pbuf_waddr = e_wp[BAW-1:0];
              pbuf_wdata = req.ch;
              ovf_next   = ovf || !np_fit;
              wp_next    = p_wp;
              pc_next    = p_pc;
              pd_next    = p_pd;
            end
            if (cl_pop) begin
              // A ".." with kept segments: fetch the previous start offset.
              stk_re         = 1'b1;
              sc_next        = e_sc - SCW'(1);
              pop_slash_next = is_slash;
              pop_last_next  = req.last;
              state_next     = S_POP;
            end else begin
              stk_we = cl_push;
              if (cl_full) begin
                ovf_next = 1'b1;
              end
              if (is_slash) begin
                sc_next    = c_sc;
                ce_next    = c_ce;
                pbuf_we    = sp_fit;
                pbuf_waddr = c_ce[BAW-1:0];
                pbuf_wdata = SLASH_CH;
                if (!sp_fit) begin
                  ovf_next = 1'b1;
                end
                wp_next   = req.last ? c_ce : sp_wp;
                pc_next   = '0;
                pd_next   = '0;
                done_next = req.last;
              end else if (req.last) begin
                sc_next   = c_sc;
                ce_next   = c_ce;
                wp_next   = c_ce;
                pc_next   = '0;
                pd_next   = '0;
                done_next = 1'b1;
              end
              finish = 1'b1;
            end
          end
        end
      end

      S_POP: begin
        // The popped offset becomes the committed end.
        ce_next = pop_ce;
        pc_next = '0;
        pd_next = '0;
        if (pop_slash) begin
          pbuf_we    = 1'b1;
          pbuf_waddr = stk_rdata;
          pbuf_wdata = SLASH_CH;
          wp_next    = pop_last ? pop_ce : pop_ce + PW'(1);
          done_next  = pop_last;
        end else begin
          wp_next   = pop_ce;
          done_next = 1'b1;
        end
        finish = 1'b1;
      end

      S_READ: begin
        case (rd_sel)
          RD_SLASH: res_char = SLASH_CH;
          RD_MEM:   res_char = pbuf_rdata;
          default:  res_char = '0;
        endcase
        finish = 1'b1;
      end

      S_HOLD: begin
        // Result parked until the output register frees up.
        if (out_free) begin
          o_valid_next = 1'b1;
          o_char_next  = hold_char;
          o_len_next   = (ce == '0) ? LEN_W'(1) : LEN_W'(ce);
          o_ovf_next   = ovf;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Hand the result to the output register, or park it.
    if (finish) begin
      if (out_free) begin
        o_valid_next = 1'b1;
        o_char_next  = res_char;
        o_len_next   = (ce_next == '0) ? LEN_W'(1) : LEN_W'(ce_next);
        o_ovf_next   = ovf_next;
        state_next   = S_IDLE;
      end else begin
        hold_char_next = res_char;
        state_next     = S_HOLD;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sc      <= '0;
      ce      <= '0;
      wp      <= '0;
      pc      <= '0;
      pd      <= '0;
      done    <= 1'b0;
      ovf     <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      sc      <= sc_next;
      ce      <= ce_next;
      wp      <= wp_next;
      pc      <= pc_next;
      pd      <= pd_next;
      done    <= done_next;
      ovf     <= ovf_next;
      o_valid <= o_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pop_slash <= pop_slash_next;
    pop_last  <= pop_last_next;
    rd_sel    <= rd_sel_next;
    hold_char <= hold_char_next;
    o_char    <= o_char_next;
    o_len     <= o_len_next;
    o_ovf     <= o_ovf_next;
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = o_valid;
  assign rsp.out_char     = o_char;
  assign rsp.canon_length = o_len;
  assign rsp.overflow     = o_ovf;

  // The committed part never runs past the segment being received.
  `PCAN_ASSERT_NOW(a_ce_le_wp, 1'b1, ce <= wp, "committed end beyond write pointer")
  // In S_IDLE, a committed end past zero always has a segment on the stack.
  `PCAN_ASSERT_NOW(a_ce_has_seg, state == S_IDLE && ce != '0, sc != '0,
    "committed bytes without a stacked segment")
  // A parked result only exists while the output register is occupied.
  `PCAN_ASSERT_NOW(a_hold_full, state == S_HOLD, o_valid, "result parked with output free")
  // A read request always waits in S_READ for the buffer data.
  `PCAN_ASSERT_NEXT(a_read_wait, req.valid && req.ready && req.op == OP_READ,
    state == S_READ, "read request did not wait for buffer data")

endmodule

`default_nettype wire
